>>> hdl/cgm_pkg.sv
// Shared types, constants and the control program of the coverage grid map engine.
// Depends on nothing; cgm_datapath, cgm_sequencer and the top level refer to it by scoped names.
package cgm_pkg;

   localparam logic [2:0] MODE_CLEAR    = 3'd0;
   localparam logic [2:0] MODE_WRITE    = 3'd1;
   localparam logic [2:0] MODE_READ     = 3'd2;
   localparam logic [2:0] MODE_OBSTACLE = 3'd3;
   localparam logic [2:0] MODE_ROBOT    = 3'd4;
   localparam logic [2:0] MODE_SCAN     = 3'd5;
   localparam logic [2:0] MODE_MERGE    = 3'd6;

   localparam logic [2:0] CELL_UNCOVERED = 3'd0;
   localparam logic [2:0] CELL_EMPTY     = 3'd1;
   localparam logic [2:0] CELL_BUSY      = 3'd2;
   localparam logic [2:0] CELL_CLEANED   = 3'd3;
   localparam logic [2:0] CELL_ROBOT     = 3'd4;

   typedef struct packed {
      logic [2:0] mode;
      logic [7:0] row;
      logic [7:0] col;
      logic [2:0] new_state;
      logic [7:0] robot_row;
      logic [7:0] robot_col;
      logic [1:0] heading;
      logic [7:0] old_row;
      logic [7:0] old_col;
   } req_type;

   typedef struct packed {
      logic [2:0] read_state;
      logic       found;
      logic [7:0] found_row;
      logic [7:0] found_col;
      logic       range_error;
   } rsp_type;

   typedef enum logic [2:0] {
      A_ITEM, A_OLD, A_ROBOT, A_CUR, A_SWEEP
   } asel_type;

   typedef enum logic [1:0] {
      M_NONE, M_READ, M_WRITE
   } mem_type;

   typedef enum logic [2:0] {
      W_ZERO, W_BUSY, W_NEWST, W_SWEEP, W_ROBOT
   } wsel_type;

   typedef enum logic [1:0] {
      CAP_NONE, CAP_READ, CAP_FOUND
   } cap_type;

   typedef enum logic [2:0] {
      CNT_NONE, CNT_ZERO, CNT_RM, CNT_CM, CNT_SWEEP
   } cnt_type;

   typedef enum logic [2:0] {
      J_NEXT, J_ALWAYS, J_NOT_LAST, J_SWEEP_END, J_SCAN_MORE
   } jump_type;

   localparam int STEP_W = 5;

   localparam logic [STEP_W-1:0] S_CLR0 = 5'd0;
   localparam logic [STEP_W-1:0] S_CLR1 = 5'd1;
   localparam logic [STEP_W-1:0] S_CLR2 = 5'd2;
   localparam logic [STEP_W-1:0] S_WR0  = 5'd3;
   localparam logic [STEP_W-1:0] S_RD0  = 5'd4;
   localparam logic [STEP_W-1:0] S_RD1  = 5'd5;
   localparam logic [STEP_W-1:0] S_OB0  = 5'd6;
   localparam logic [STEP_W-1:0] S_OB1  = 5'd7;
   localparam logic [STEP_W-1:0] S_OB2  = 5'd8;
   localparam logic [STEP_W-1:0] S_OB3  = 5'd9;
   localparam logic [STEP_W-1:0] S_OB4  = 5'd10;
   localparam logic [STEP_W-1:0] S_RB0  = 5'd11;
   localparam logic [STEP_W-1:0] S_RB1  = 5'd12;
   localparam logic [STEP_W-1:0] S_RB2  = 5'd13;
   localparam logic [STEP_W-1:0] S_RB3  = 5'd14;
   localparam logic [STEP_W-1:0] S_SC0  = 5'd15;
   localparam logic [STEP_W-1:0] S_SC1  = 5'd16;
   localparam logic [STEP_W-1:0] S_SC2  = 5'd17;
   localparam logic [STEP_W-1:0] S_SC3  = 5'd18;
   localparam logic [STEP_W-1:0] S_MG0  = 5'd19;
   localparam logic [STEP_W-1:0] S_MG1  = 5'd20;
   localparam logic [STEP_W-1:0] S_NOP  = 5'd21;

   typedef struct packed {
      asel_type          asel;
      mem_type           mem;
      wsel_type          wsel;
      logic              errchk;
      cap_type           cap;
      cnt_type           cnt;
      jump_type          jump;
      logic [STEP_W-1:0] target;
      logic              done;
   } ucode_type;

   typedef struct packed {
      logic     exec;
      asel_type asel;
      mem_type  mem;
      wsel_type wsel;
      logic     errchk;
      cap_type  cap;
      cnt_type  cnt;
   } ctrl_type;

   typedef struct packed {
      logic at_last;
      logic sweep_more;
      logic hit_empty;
   } status_type;

   function automatic logic [STEP_W-1:0] entry(input logic [2:0] mode);
      logic [STEP_W-1:0] s;
      unique case (mode)
         MODE_CLEAR:    s = S_CLR0;
         MODE_WRITE:    s = S_WR0;
         MODE_READ:     s = S_RD0;
         MODE_OBSTACLE: s = S_OB0;
         MODE_ROBOT:    s = S_RB0;
         MODE_SCAN:     s = S_SC0;
         MODE_MERGE:    s = S_MG0;
         default:       s = S_NOP;
      endcase
      return s;
   endfunction

   function automatic ucode_type ucode(input logic [STEP_W-1:0] step);
      ucode_type w;
      w = '0;
      unique case (step)
         S_CLR0: begin
            w.cnt = CNT_ZERO;
         end
         S_CLR1: begin
            w.asel = A_CUR;    w.mem = M_WRITE; w.wsel = W_ZERO;
            w.cnt = CNT_RM;    w.jump = J_NOT_LAST; w.target = S_CLR1;
         end
         S_CLR2: begin
            w.done = 1'b1;
         end
         S_WR0: begin
            w.asel = A_ITEM;   w.mem = M_WRITE; w.wsel = W_NEWST;
            w.errchk = 1'b1;   w.done = 1'b1;
         end
         S_RD0: begin
            w.asel = A_ITEM;   w.mem = M_READ;  w.errchk = 1'b1;
         end
         S_RD1: begin
            w.asel = A_ITEM;   w.cap = CAP_READ; w.done = 1'b1;
         end
         S_OB0: begin
            w.asel = A_ITEM;   w.mem = M_WRITE; w.wsel = W_BUSY;
            w.errchk = 1'b1;   w.cnt = CNT_ZERO;
         end
         S_OB1: begin
            w.jump = J_SWEEP_END; w.target = S_OB4;
         end
         S_OB2: begin
            w.asel = A_SWEEP;  w.mem = M_READ;  w.errchk = 1'b1;
         end
         S_OB3: begin
            w.asel = A_SWEEP;  w.mem = M_WRITE; w.wsel = W_SWEEP;
            w.cnt = CNT_SWEEP; w.jump = J_ALWAYS; w.target = S_OB1;
         end
         S_OB4: begin
            w.done = 1'b1;
         end
         S_RB0: begin
            w.asel = A_ROBOT;  w.errchk = 1'b1; w.cnt = CNT_ZERO;
         end
         S_RB1: begin
            w.asel = A_CUR;    w.mem = M_READ;
         end
         S_RB2: begin
            w.asel = A_CUR;    w.mem = M_WRITE; w.wsel = W_ROBOT;
            w.cnt = CNT_RM;    w.jump = J_NOT_LAST; w.target = S_RB1;
         end
         S_RB3: begin
            w.done = 1'b1;
         end
         S_SC0: begin
            w.cnt = CNT_ZERO;
         end
         S_SC1: begin
            w.asel = A_CUR;    w.mem = M_READ;
         end
         S_SC2: begin
            w.asel = A_CUR;    w.cap = CAP_FOUND; w.cnt = CNT_CM;
            w.jump = J_SCAN_MORE; w.target = S_SC1;
         end
         S_SC3: begin
            w.done = 1'b1;
         end
         S_MG0: begin
            w.asel = A_OLD;    w.mem = M_WRITE; w.wsel = W_ZERO;
            w.errchk = 1'b1;
         end
         S_MG1: begin
            w.asel = A_ITEM;   w.mem = M_WRITE; w.wsel = W_BUSY;
            w.errchk = 1'b1;   w.done = 1'b1;
         end
         default: begin
            w.done = 1'b1;
         end
      endcase
      return w;
   endfunction

endpackage

>>> hdl/cgm_grid_ram.sv
// Single-port grid memory with registered read data, one 3-bit state per entry.
// Depends on nothing; instantiated by cgm_datapath.
module cgm_grid_ram #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic          clock,
   input  logic          en,
   input  logic          we,
   input  logic [AW-1:0] addr,
   input  logic [2:0]    wdata,
   output logic [2:0]    rdata
);

   logic [2:0] grid_ff [DEPTH];
   logic [2:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            grid_ff[addr] <= wdata;
         end else begin
            rdata_ff <= grid_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> hdl/cgm_datapath.sv
// Datapath: item and mode registers, position counters, address and write-data logic,
// result accumulators and the grid memory. Depends on cgm_pkg and cgm_grid_ram.
module cgm_datapath #(
   parameter int ROWS = 32,
   parameter int COLS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  cgm_pkg::req_type    req,
   input  logic                csr_write_en,
   input  logic                csr_write_data,
   input  cgm_pkg::ctrl_type   ctrl,
   output cgm_pkg::status_type status,
   output cgm_pkg::rsp_type    res_next
);

   localparam int DEPTH = ROWS * COLS;
   localparam int AW    = $clog2(DEPTH);
   localparam logic [7:0] LAST_R = 8'(ROWS - 1);
   localparam logic [7:0] LAST_C = 8'(COLS - 1);
   localparam logic [8:0] ROWS_9 = 9'(ROWS);
   localparam logic [8:0] COLS_9 = 9'(COLS);

   cgm_pkg::req_type item_ff;
   logic             rmode_ff;
   logic [7:0]       cur_r_ff, cur_r_in, cur_c_ff, cur_c_in;
   logic [8:0]       idx_ff, idx_in;
   logic [2:0]       rd_ff, rd_in;
   logic             fnd_ff, fnd_in;
   logic [7:0]       frow_ff, frow_in, fcol_ff, fcol_in;
   logic             err_ff, err_in;

   logic             axis_rows;
   logic [7:0]       span_a, span_b, lo, hi;
   logic [8:0]       ptr_r, ptr_c;
   logic             in_grid, at_last, robot_hit, wq;
   logic [AW-1:0]    addr;
   logic [2:0]       wdata, rdata;
   logic             ram_en, ram_we;

   always_comb begin
      axis_rows = item_ff.heading[0];
      span_a    = axis_rows ? item_ff.robot_row : item_ff.robot_col;
      span_b    = axis_rows ? item_ff.row : item_ff.col;
      lo        = (span_a < span_b) ? span_a : span_b;
      hi        = (span_a < span_b) ? span_b : span_a;
   end

   always_comb begin
      case (ctrl.asel)
         cgm_pkg::A_ITEM: begin
            ptr_r = {1'b0, item_ff.row};
            ptr_c = {1'b0, item_ff.col};
         end
         cgm_pkg::A_OLD: begin
            ptr_r = {1'b0, item_ff.old_row};
            ptr_c = {1'b0, item_ff.old_col};
         end
         cgm_pkg::A_ROBOT: begin
            ptr_r = {1'b0, item_ff.robot_row};
            ptr_c = {1'b0, item_ff.robot_col};
         end
         cgm_pkg::A_CUR: begin
            ptr_r = {1'b0, cur_r_ff};
            ptr_c = {1'b0, cur_c_ff};
         end
         cgm_pkg::A_SWEEP: begin
            ptr_r = axis_rows ? idx_ff : {1'b0, item_ff.row};
            ptr_c = axis_rows ? {1'b0, item_ff.col} : idx_ff;
         end
         default: begin
            ptr_r = '0;
            ptr_c = '0;
         end
      endcase
      in_grid = (ptr_r < ROWS_9) && (ptr_c < COLS_9);
      addr    = in_grid ? (AW'(ptr_r) * AW'(COLS) + AW'(ptr_c)) : '0;
   end

   always_comb begin
      robot_hit = (cur_r_ff == item_ff.robot_row) && (cur_c_ff == item_ff.robot_col);
      case (ctrl.wsel)
         cgm_pkg::W_ZERO: begin
            wdata = cgm_pkg::CELL_UNCOVERED;
            wq    = 1'b1;
         end
         cgm_pkg::W_BUSY: begin
            wdata = cgm_pkg::CELL_BUSY;
            wq    = 1'b1;
         end
         cgm_pkg::W_NEWST: begin
            wdata = item_ff.new_state;
            wq    = item_ff.new_state <= cgm_pkg::CELL_ROBOT;
         end
         cgm_pkg::W_SWEEP: begin
            wdata = cgm_pkg::CELL_EMPTY;
            wq    = (rdata != cgm_pkg::CELL_CLEANED) && (rdata != cgm_pkg::CELL_BUSY);
         end
         cgm_pkg::W_ROBOT: begin
            wdata = robot_hit ? cgm_pkg::CELL_ROBOT
                  : (rmode_ff ? cgm_pkg::CELL_EMPTY : cgm_pkg::CELL_CLEANED);
            wq    = robot_hit || (rdata == cgm_pkg::CELL_ROBOT);
         end
         default: begin
            wdata = cgm_pkg::CELL_UNCOVERED;
            wq    = 1'b0;
         end
      endcase
      ram_en = ctrl.exec && (ctrl.mem != cgm_pkg::M_NONE);
      ram_we = (ctrl.mem == cgm_pkg::M_WRITE) && in_grid && wq;
   end

   cgm_grid_ram #(
      .DEPTH(DEPTH),
      .AW   (AW)
   ) u_ram (
      .clock(clock),
      .en   (ram_en),
      .we   (ram_we),
      .addr (addr),
      .wdata(wdata),
      .rdata(rdata)
   );

   always_comb begin
      at_last           = (cur_r_ff == LAST_R) && (cur_c_ff == LAST_C);
      status.at_last    = at_last;
      status.sweep_more = idx_ff < {1'b0, hi};
      status.hit_empty  = rdata == cgm_pkg::CELL_EMPTY;
   end

   // advance position counters
   always_comb begin
      cur_r_in = cur_r_ff;
      cur_c_in = cur_c_ff;
      idx_in   = idx_ff;
      if (ctrl.exec) begin
         case (ctrl.cnt)
            cgm_pkg::CNT_ZERO: begin
               cur_r_in = '0;
               cur_c_in = '0;
               idx_in   = {1'b0, lo} + 9'd1;
            end
            cgm_pkg::CNT_RM: begin
               if (cur_c_ff == LAST_C) begin
                  cur_c_in = '0;
                  cur_r_in = cur_r_ff + 8'd1;
               end else begin
                  cur_c_in = cur_c_ff + 8'd1;
               end
            end
            cgm_pkg::CNT_CM: begin
               if (cur_r_ff == LAST_R) begin
                  cur_r_in = '0;
                  cur_c_in = cur_c_ff + 8'd1;
               end else begin
                  cur_r_in = cur_r_ff + 8'd1;
               end
            end
            cgm_pkg::CNT_SWEEP: begin
               idx_in = idx_ff + 9'd1;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rd_in   = rd_ff;
      fnd_in  = fnd_ff;
      frow_in = frow_ff;
      fcol_in = fcol_ff;
      err_in  = err_ff;
      if (start) begin
         rd_in   = '0;
         fnd_in  = 1'b0;
         frow_in = '0;
         fcol_in = '0;
         err_in  = 1'b0;
      end else if (ctrl.exec) begin
         if (ctrl.errchk && !in_grid) begin
            err_in = 1'b1;
         end
         if (ctrl.cap == cgm_pkg::CAP_READ) begin
            rd_in = in_grid ? rdata : cgm_pkg::CELL_UNCOVERED;
         end
         if ((ctrl.cap == cgm_pkg::CAP_FOUND) && status.hit_empty) begin
            fnd_in  = 1'b1;
            frow_in = cur_r_ff;
            fcol_in = cur_c_ff;
         end
      end
   end

   always_comb begin
      res_next.read_state  = rd_in;
      res_next.found       = fnd_in;
      res_next.found_row   = frow_in;
      res_next.found_col   = fcol_in;
      res_next.range_error = err_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rmode_ff <= 1'b0;
      end else if (csr_write_en) begin
         rmode_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         item_ff <= req;
      end
      cur_r_ff <= cur_r_in;
      cur_c_ff <= cur_c_in;
      idx_ff   <= idx_in;
      rd_ff    <= rd_in;
      fnd_ff   <= fnd_in;
      frow_ff  <= frow_in;
      fcol_ff  <= fcol_in;
      err_ff   <= err_in;
   end

endmodule

>>> hdl/cgm_sequencer.sv
// Microcode sequencer: step counter, control ROM lookup, dispatch and conditional jumps.
// Depends on cgm_pkg for the control word types, entry points and program.
module cgm_sequencer (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [2:0]          mode,
   input  logic                out_blocked,
   input  cgm_pkg::status_type status,
   output cgm_pkg::ctrl_type   ctrl,
   output logic                busy,
   output logic                emit
);

   logic [cgm_pkg::STEP_W-1:0] step_ff, step_in;
   logic                       busy_ff, busy_in;
   logic                       silent_ff, silent_in;
   cgm_pkg::ucode_type         uc;
   logic                       exec, take;

   always_comb begin
      uc   = cgm_pkg::ucode(step_ff);
      // hold a finishing step while the result register is still occupied
      exec = busy_ff && !(uc.done && out_blocked);
      unique case (uc.jump)
         cgm_pkg::J_NEXT:      take = 1'b0;
         cgm_pkg::J_ALWAYS:    take = 1'b1;
         cgm_pkg::J_NOT_LAST:  take = !status.at_last;
         cgm_pkg::J_SWEEP_END: take = !status.sweep_more;
         cgm_pkg::J_SCAN_MORE: take = !status.hit_empty && !status.at_last;
         default:              take = 1'b0;
      endcase
   end

   always_comb begin
      step_in   = step_ff;
      busy_in   = busy_ff;
      silent_in = silent_ff;
      if (start) begin
         step_in   = cgm_pkg::entry(mode);
         busy_in   = 1'b1;
         silent_in = 1'b0;
      end else if (exec) begin
         step_in = take ? uc.target : step_ff + 1'b1;
         if (uc.done) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff   <= cgm_pkg::S_CLR0;
         busy_ff   <= 1'b1;
         silent_ff <= 1'b1;
      end else begin
         step_ff   <= step_in;
         busy_ff   <= busy_in;
         silent_ff <= silent_in;
      end
   end

   always_comb begin
      ctrl.exec   = exec;
      ctrl.asel   = uc.asel;
      ctrl.mem    = uc.mem;
      ctrl.wsel   = uc.wsel;
      ctrl.errchk = uc.errchk;
      ctrl.cap    = uc.cap;
      ctrl.cnt    = uc.cnt;
      busy        = busy_ff;
      emit        = exec && uc.done && !silent_ff;
   end

endmodule

>>> hdl/coverage_grid_map_engine_unit.sv
// Coverage grid map engine, top level: handshakes, result register, sequencer and datapath.
// Depends on cgm_pkg, cgm_sequencer and cgm_datapath.
//
// Usage:
//   req_valid/req_stall/req_data carry one operation per transfer; rsp_valid/rsp_stall/
//   rsp_data return exactly one result per operation, in order. csr_write_en and
//   csr_write_data set return_mode; write it only while no operation is in flight.
//   One operation at a time: req_stall stays high from a transfer until its last step runs.
//   Steps per operation: write is one grid write; merge writes the old cell then the new;
//   read reads then captures; clear writes every cell in row-major order; robot update
//   reads and writes every cell; scan reads cells in column-major order until an empty one
//   or the last; obstacle marks its cell busy, then reads and writes each cell inside the span.
//   The grid memory is single-port, one access per cycle, so a
//   read-modify-write visit costs a read step and a write step.
//   Reset runs a clearing pass of the whole grid with req_stall high; it gives no result.
//   The result register frees the engine: a new request is taken while a result waits.
//   If rsp_stall holds a result, the next operation runs up to its final step and holds there.
module coverage_grid_map_engine_unit #(
   parameter int ROWS = 32,
   parameter int COLS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cgm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cgm_pkg::rsp_type rsp_data,
   input  logic             csr_write_en,
   input  logic             csr_write_data
);

   cgm_pkg::ctrl_type   ctrl;
   cgm_pkg::status_type status;
   cgm_pkg::rsp_type    res_next;
   cgm_pkg::rsp_type    rsp_data_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                busy, emit, accept, out_blocked;

   always_comb begin
      accept      = req_valid && !busy;
      out_blocked = rsp_valid_ff && rsp_stall;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   cgm_sequencer u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (accept),
      .mode       (req_data.mode),
      .out_blocked(out_blocked),
      .status     (status),
      .ctrl       (ctrl),
      .busy       (busy),
      .emit       (emit)
   );

   cgm_datapath #(
      .ROWS(ROWS),
      .COLS(COLS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .start         (accept),
      .req           (req_data),
      .csr_write_en  (csr_write_en),
      .csr_write_data(csr_write_data),
      .ctrl          (ctrl),
      .status        (status),
      .res_next      (res_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff <= res_next;
      end
   end

   assign req_stall = busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_emit_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      emit |-> !(rsp_valid_ff && rsp_stall))
      else $error("result written over a held result");

   a_accept_then_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("engine not busy after request transfer");

   a_result_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(busy))
      else $error("result raised without an operation in flight");

endmodule
